// ===== hdl/cb_beacon_message_unpack_macros.svh =====
// Assertion macros shared by the beacon message unpacker RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef CB_BEACON_MESSAGE_UNPACK_MACROS_SVH
`define CB_BEACON_MESSAGE_UNPACK_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CBMU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbmu check failed");
// Next-cycle implication, disabled during reset.
`define CBMU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbmu check failed");
`else
`define CBMU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CBMU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/cbmu_pkg.sv =====
// Constants, shape tables and the pipeline item type of the beacon unpacker.
// No dependencies.
`default_nettype none
package cbmu_pkg;
    localparam int SHAPES = 26;
    localparam int PEELS  = 8;

    localparam logic [29:0] CALL_LIMIT = 30'd935913420;
    localparam logic [14:0] GRID_LIMIT = 15'd32400;
    localparam logic [4:0]  POWER_MAX  = 5'd18;

    localparam logic [7:0]  ASCII_ZERO = 8'h30;
    localparam logic [7:0]  ASCII_A    = 8'h41;
    localparam logic [31:0] GRID_BAD   = 32'h58585858;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SUPPRESS = 2'd1;
    localparam logic [1:0] ST_GRID_BAD = 2'd2;

    // Reciprocals for quotients of values below 2^30, shift by 35.
    localparam logic [31:0] RECIP10 = 32'd3435973837;
    localparam logic [31:0] RECIP26 = 32'd1321528400;

    localparam logic [29:0] SHAPE_BASE [SHAPES] = '{
        30'd0,         30'd260,       30'd2860,      30'd28860,     30'd288860,
        30'd2888860,   30'd2895620,   30'd2963220,   30'd3639220,   30'd10399220,
        30'd77999220,  30'd78001820,  30'd78027820,  30'd78287820,  30'd80887820,
        30'd80955420,  30'd81631420,  30'd88391420,  30'd155991420, 30'd156017420,
        30'd156277420, 30'd158877420, 30'd184877420, 30'd185553420, 30'd192313420,
        30'd259913420
    };
    localparam logic [29:0] SHAPE_END [SHAPES] = '{
        30'd260,       30'd2860,      30'd28860,     30'd288860,    30'd2888860,
        30'd2895620,   30'd2963220,   30'd3639220,   30'd10399220,  30'd77999220,
        30'd78001820,  30'd78027820,  30'd78287820,  30'd80887820,  30'd80955420,
        30'd81631420,  30'd88391420,  30'd155991420, 30'd156017420, 30'd156277420,
        30'd158877420, 30'd184877420, 30'd185553420, 30'd192313420, 30'd259913420,
        30'd935913420
    };
    localparam logic [1:0] SHAPE_NPRE [SHAPES] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };
    localparam logic [1:0] SHAPE_NLET [SHAPES] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
    };
    localparam logic [2:0] SHAPE_NSFX [SHAPES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3
    };

    // One item in flight through the character stages.
    typedef struct packed {
        logic [29:0] rem;     // value still to be taken apart
        logic [63:0] text;    // characters so far, first at the top
        logic [3:0]  len;     // total characters, zero when out of range
        logic [2:0]  nsfx;    // suffix digit count
        logic [3:0]  nlow;    // suffix digits plus letters
        logic [3:0]  pos;     // characters peeled so far, from the end
        logic [31:0] grid;
        logic [6:0]  pwr;
        logic [1:0]  status;
    } peel_t;
endpackage
`default_nettype wire

// ===== hdl/cb_beacon_message_unpack.sv =====
// Stages from input accept to result valid: shape search, offset and grid finish,
// then eight character stages. Throughput: one item per cycle while the result is taken.
// The whole pipeline advances together; it holds when the result is not taken.
// Reset (aresetn low, synchronous) clears all stage valid bits; data needs none.
`default_nettype none
`include "cb_beacon_message_unpack_macros.svh"
module cb_beacon_message_unpack (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [49:0] s_message_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_call_text,
    output logic [3:0]       m_call_length,
    output logic [31:0]      m_grid_text,
    output logic [6:0]       m_power_dbm,
    output logic [1:0]       m_status
);
    import cbmu_pkg::*;

    // Advance every stage when the output slot is empty or being drained.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- Stage 1: split fields, shape search, grid column, power
    logic [29:0] cidx;
    logic [14:0] gidx;
    logic [4:0]  pidx;
    logic [SHAPES-1:0] below;
    logic [4:0]  shape;
    logic        over;
    logic [30:0] gprod;
    logic [8:0]  pprod;
    logic [3:0]  pq;
    logic [1:0]  prem;
    logic [6:0]  pdbm;
    logic        grid_ok;
    logic [1:0]  status1;

    always_comb begin
        cidx  = s_message_bits[49:20];
        gidx  = s_message_bits[19:5];
        pidx  = s_message_bits[4:0];
        // Compare against every block end in parallel, take the first hit.
        for (int s = 0; s < SHAPES; s++) begin
            below[s] = cidx < SHAPE_END[s];
        end
        shape = '0;
        for (int s = SHAPES - 1; s >= 0; s--) begin
            if (below[s]) begin
                shape = 5'(s);
            end
        end
        over = !below[SHAPES-1];
        // Column is gidx / 180 by reciprocal.
        gprod = 31'(gidx) * 31'd46604;
        // Power: p / 3 by reciprocal, then table for the remainder.
        pprod = 9'(pidx) * 9'd11;
        pq    = pprod[8:5];
        prem  = 2'(pidx - 5'(pq) * 5'd3);
        case (prem)
            2'd1:    pdbm = 7'(pq) * 7'd10 + 7'd3;
            2'd2:    pdbm = 7'(pq) * 7'd10 + 7'd7;
            default: pdbm = 7'(pq) * 7'd10;
        endcase
        grid_ok = gidx < GRID_LIMIT;
        if (!grid_ok) begin
            status1 = ST_GRID_BAD;
        end else if (over || (pidx > POWER_MAX)) begin
            status1 = ST_SUPPRESS;
        end else begin
            status1 = ST_OK;
        end
    end

    logic        s1_valid_reg;
    logic [29:0] s1_cidx_reg;
    logic [4:0]  s1_shape_reg;
    logic        s1_over_reg;
    logic [7:0]  s1_gcol_reg;
    logic [14:0] s1_gidx_reg;
    logic        s1_gok_reg;
    logic [6:0]  s1_pwr_reg;
    logic [1:0]  s1_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
        if (adv) begin
            s1_cidx_reg   <= cidx;
            s1_shape_reg  <= shape;
            s1_over_reg   <= over;
            s1_gcol_reg   <= gprod[30:23];
            s1_gidx_reg   <= gidx;
            s1_gok_reg    <= grid_ok;
            s1_pwr_reg    <= pdbm;
            s1_status_reg <= status1;
        end
    end

    // ---------------- Stage 2: offset inside the shape, finish the locator
    logic [14:0] lat_full;
    logic [7:0]  lat;
    logic [8:0]  lonv;
    logic [21:0] lon_prod;
    logic [4:0]  lon_l;
    logic [8:0]  lon_rest;
    logic [18:0] lat_prod;
    logic [4:0]  lat_l;
    logic [7:0]  lat_d;
    logic [31:0] grid_text;
    peel_t       s2_next;

    always_comb begin
        lat_full = s1_gidx_reg - 15'(s1_gcol_reg) * 15'd180;
        lat      = lat_full[7:0];
        lonv     = 9'd358 - {s1_gcol_reg, 1'b0};
        // Longitude letter is lonv / 20, digit is (lonv % 20) / 2.
        lon_prod = 22'(lonv) * 22'd6554;
        lon_l    = lon_prod[21:17];
        lon_rest = lonv - 9'(lon_l) * 9'd20;
        // Latitude letter is lat / 10, digit lat % 10.
        lat_prod = 19'(lat) * 19'd205;
        lat_l    = lat_prod[15:11];
        lat_d    = lat - 8'(lat_l) * 8'd10;
        if (s1_gok_reg) begin
            grid_text = {ASCII_A + 8'(lon_l), ASCII_A + 8'(lat_l),
                         ASCII_ZERO + 8'(lon_rest[4:1]), ASCII_ZERO + lat_d};
        end else begin
            grid_text = GRID_BAD;
        end

        s2_next        = '0;
        s2_next.grid   = grid_text;
        s2_next.pwr    = s1_pwr_reg;
        s2_next.status = s1_status_reg;
        if (!s1_over_reg) begin
            s2_next.rem  = s1_cidx_reg - SHAPE_BASE[s1_shape_reg];
            s2_next.len  = 4'(SHAPE_NPRE[s1_shape_reg]) + 4'(SHAPE_NLET[s1_shape_reg])
                         + 4'(SHAPE_NSFX[s1_shape_reg]);
            s2_next.nsfx = SHAPE_NSFX[s1_shape_reg];
            s2_next.nlow = 4'(SHAPE_NLET[s1_shape_reg]) + 4'(SHAPE_NSFX[s1_shape_reg]);
        end
    end

    logic  s2_valid_reg;
    peel_t s2_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            s2_item_reg <= s2_next;
        end
    end

    // ---------------- Stages 3..10: at most one callsign character per stage, last first
    logic  pv [PEELS+1];
    peel_t pi [PEELS+1];

    assign pv[0] = s2_valid_reg;
    assign pi[0] = s2_item_reg;

    for (genvar k = 0; k < PEELS; k++) begin : g_peel
        cbmu_peel u_peel (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (pv[k]),
            .in_item   (pi[k]),
            .out_valid (pv[k+1]),
            .out_item  (pi[k+1])
        );
    end

    // The last character stage is the output register.
    assign m_valid       = pv[PEELS];
    assign m_call_text   = pi[PEELS].text;
    assign m_call_length = pi[PEELS].len;
    assign m_grid_text   = pi[PEELS].grid;
    assign m_power_dbm   = pi[PEELS].pwr;
    assign m_status      = pi[PEELS].status;

    `CBMU_ASSERT_NOW(a_len_range, aclk, aresetn, m_valid, m_call_length <= 4'd8)
    `CBMU_ASSERT_NOW(a_all_peeled, aclk, aresetn, m_valid, pi[PEELS].pos == m_call_length)
    `CBMU_ASSERT_NOW(a_grid_bad, aclk, aresetn, m_valid && (m_status == ST_GRID_BAD), m_grid_text == GRID_BAD)
    `CBMU_ASSERT_NOW(a_empty_call, aclk, aresetn, m_valid && (m_call_length == 4'd0), m_call_text == 64'd0)
    `CBMU_ASSERT_NXT(a_hold, aclk, aresetn, s2_valid_reg && !adv, s2_valid_reg)
endmodule
`default_nettype wire

// ===== hdl/cbmu_peel.sv =====
// One character stage: peel the lowest mixed-radix digit off the call index while characters remain.
// Depends on cbmu_pkg.
`default_nettype none
module cbmu_peel (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  cbmu_pkg::peel_t    in_item,
    output logic               out_valid,
    output cbmu_pkg::peel_t    out_item
);
    import cbmu_pkg::*;

    logic        valid_reg;
    peel_t       item_reg;
    peel_t       item_next;
    logic        radix10;
    logic [31:0] recip;
    logic [61:0] prod;
    logic [26:0] quot;
    logic [29:0] back;
    logic [4:0]  digit;
    logic [7:0]  ch;

    always_comb begin
        radix10   = !((in_item.pos >= {1'b0, in_item.nsfx}) && (in_item.pos < in_item.nlow));
        recip     = radix10 ? RECIP10 : RECIP26;
        prod      = 62'(in_item.rem) * 62'(recip);
        quot      = prod[61:35];
        back      = radix10 ? 30'(quot) * 30'd10 : 30'(quot) * 30'd26;
        digit     = 5'(in_item.rem - back);
        ch        = (radix10 ? ASCII_ZERO : ASCII_A) + 8'(digit);
        item_next = in_item;
        if (in_item.pos < in_item.len) begin
            item_next.rem  = 30'(quot);
            item_next.text = {ch, in_item.text[63:8]};
            item_next.pos  = in_item.pos + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule
`default_nettype wire
